>>> rtl/ottc_pkg.sv
// Package: shared types and constants for the track table counter.
`default_nettype none
package ottc_pkg;
   localparam int MAX_TRACKS_DEF = 16;
   localparam int COORD_BITS_DEF = 12;
   localparam logic [7:0] RELOAD_DEFAULT = 8'd9;
   localparam logic [7:0] HIT_MAX = 8'd255;
   localparam logic OP_DETECT = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   typedef struct packed {
      logic        op;
      logic [11:0] rect_x;
      logic [11:0] rect_y;
      logic [11:0] rect_w;
      logic [11:0] rect_h;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [3:0]  slot;
      logic        dropped;
      logic [4:0]  expired_count;
      logic [15:0] net_count;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/overlap_track_table_counter.sv
// Top level: track table counter, queue front end and scanning back end.
// A detection scan stops at the first matching entry or at the last; a frame tick scans every entry.
// The back end takes a new item only after its last response is accepted, and it scans
// the table one entry per cycle; a two-beat queue absorbs bursts.
// Reset (synchronous, high): clear table valid bits, net count, queue; reload=9.
`default_nettype none
module overlap_track_table_counter #(
   parameter int MAX_TRACKS = ottc_pkg::MAX_TRACKS_DEF,
   parameter int COORD_BITS = ottc_pkg::COORD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ottc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ottc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata
);
   // Lifetime reload register.
   logic [7:0] reload_ff;
   always_ff @(posedge clock) begin
      if (reset) reload_ff <= ottc_pkg::RELOAD_DEFAULT;
      else if (csr_we) reload_ff <= csr_wdata;
   end

   logic q_valid, q_take;
   ottc_pkg::req_type q_data;

   // Hold incoming beats until the back end is free.
   ottc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   // Scan the table and drive the result beat.
   ottc_back #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .reload(reload_ff), .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

>>> rtl/ottc_front.sv
// Front end: accepts request beats into a two-entry queue.
`default_nettype none
module ottc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ottc_pkg::req_type req_data,
   output logic                   q_valid,
   input  wire logic              q_take,
   output ottc_pkg::req_type      q_data
);
   ottc_pkg::req_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_take;
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

>>> rtl/ottc_back.sv
// Back end: scans the track table one entry per cycle and builds the response.
`default_nettype none
module ottc_back #(
   parameter int MAX_TRACKS = 16,
   parameter int COORD_BITS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        reload,
   input  wire logic              q_valid,
   output logic                   q_take,
   input  wire ottc_pkg::req_type q_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ottc_pkg::rsp_type      rsp_data
);
   localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);
   localparam int EW = COORD_BITS + 1;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} st_type;
   st_type st_ff;
   logic [IW-1:0] idx_ff;
   ottc_pkg::req_type cur_ff;
   logic [MAX_TRACKS-1:0] valid_ff;
   logic [COORD_BITS-1:0] bx_ff [MAX_TRACKS], by_ff [MAX_TRACKS];
   logic [COORD_BITS-1:0] bw_ff [MAX_TRACKS], bh_ff [MAX_TRACKS];
   logic [COORD_BITS-1:0] fx_ff [MAX_TRACKS], lx_ff [MAX_TRACKS];
   logic [MAX_TRACKS-1:0] seen_ff;
   logic [7:0] fh_ff [MAX_TRACKS], pk_ff [MAX_TRACKS];
   logic [8:0] life_ff [MAX_TRACKS];
   logic signed [15:0] net_ff;
   logic free_found_ff;
   logic [IW-1:0] free_ff;
   logic [CW-1:0] exp_ff;
   ottc_pkg::rsp_type out_ff;

   logic [COORD_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh;
   logic [EW-1:0] ar, ab, br, bb, lx, ly, rx, ry;
   logic hit;
   logic [2*EW+1:0] inter3, area;
   logic last;
   logic [7:0] pk_new;
   logic signed [17:0] net_sum;
   logic signed [15:0] net_sat;

   always_comb begin
      ax = cur_ff.rect_x[COORD_BITS-1:0]; ay = cur_ff.rect_y[COORD_BITS-1:0];
      aw = cur_ff.rect_w[COORD_BITS-1:0]; ah = cur_ff.rect_h[COORD_BITS-1:0];
      bx = bx_ff[idx_ff]; by = by_ff[idx_ff]; bw = bw_ff[idx_ff]; bh = bh_ff[idx_ff];
      ar = {1'b0, ax} + {1'b0, aw}; ab = {1'b0, ay} + {1'b0, ah};
      br = {1'b0, bx} + {1'b0, bw}; bb = {1'b0, by} + {1'b0, bh};
      lx = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
      ly = (ay > by) ? {1'b0, ay} : {1'b0, by};
      rx = (ar > br) ? br : ar;
      ry = (ab > bb) ? bb : ab;
      inter3 = (2*EW+2)'(rx - lx) * (2*EW+2)'(ry - ly) * (2*EW+2)'(3);
      area = (2*EW+2)'(aw) * (2*EW+2)'(ah);
      hit = valid_ff[idx_ff] && ar > {1'b0, bx} && ab > {1'b0, by}
            && br > {1'b0, ax} && bb > {1'b0, ay} && area < inter3;
      last = (idx_ff == IW'(MAX_TRACKS - 1));
      pk_new = (pk_ff[idx_ff] < fh_ff[idx_ff]) ? fh_ff[idx_ff] : pk_ff[idx_ff];
      net_sum = 18'(net_ff);
      if (fx_ff[idx_ff] > lx_ff[idx_ff]) net_sum = net_sum + 18'(pk_new);
      else if (fx_ff[idx_ff] < lx_ff[idx_ff]) net_sum = net_sum - 18'(pk_new);
      if (net_sum > 18'sd32767) net_sat = 16'sh7fff;
      else if (net_sum < -18'sd32768) net_sat = 16'sh8000;
      else net_sat = net_sum[15:0];
   end

   assign q_take = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; valid_ff <= '0; net_ff <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (q_valid) begin
               cur_ff <= q_data; idx_ff <= '0; free_found_ff <= 1'b0;
               exp_ff <= '0; st_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (cur_ff.op == ottc_pkg::OP_DETECT) begin
                  if (hit) begin
                     lx_ff[idx_ff] <= ax; seen_ff[idx_ff] <= 1'b1;
                     if (fh_ff[idx_ff] != ottc_pkg::HIT_MAX) fh_ff[idx_ff] <= fh_ff[idx_ff] + 8'd1;
                     out_ff <= '{matched: 1'b1, slot: 4'(idx_ff), dropped: 1'b0,
                                 expired_count: 5'd0, net_count: net_ff};
                     st_ff <= S_OUT;
                  end else begin
                     if (!valid_ff[idx_ff] && !free_found_ff) begin
                        free_found_ff <= 1'b1; free_ff <= idx_ff;
                     end
                     if (last) begin
                        if (free_found_ff || !valid_ff[idx_ff]) begin
                           logic [IW-1:0] f;
                           f = free_found_ff ? free_ff : idx_ff;
                           valid_ff[f] <= 1'b1;
                           bx_ff[f] <= ax; by_ff[f] <= ay; bw_ff[f] <= aw; bh_ff[f] <= ah;
                           fx_ff[f] <= ax; lx_ff[f] <= ax; seen_ff[f] <= 1'b0;
                           fh_ff[f] <= '0; pk_ff[f] <= '0; life_ff[f] <= {1'b0, reload};
                           out_ff <= '{matched: 1'b0, slot: 4'(f), dropped: 1'b0,
                                       expired_count: 5'd0, net_count: net_ff};
                        end else
                           out_ff <= '{matched: 1'b0, slot: 4'd0, dropped: 1'b1,
                                       expired_count: 5'd0, net_count: net_ff};
                        st_ff <= S_OUT;
                     end
                  end
               end else begin
                  logic [CW-1:0] e;
                  logic signed [15:0] n;
                  e = exp_ff; n = net_ff;
                  if (valid_ff[idx_ff]) begin
                     seen_ff[idx_ff] <= 1'b0; fh_ff[idx_ff] <= '0; pk_ff[idx_ff] <= pk_new;
                     if (seen_ff[idx_ff]) life_ff[idx_ff] <= {1'b0, reload};
                     else if (life_ff[idx_ff] == 9'd0) begin
                        valid_ff[idx_ff] <= 1'b0; e = e + CW'(1); n = net_sat;
                     end else life_ff[idx_ff] <= life_ff[idx_ff] - 9'd1;
                  end
                  exp_ff <= e; net_ff <= n;
                  if (last) begin
                     out_ff <= '{matched: 1'b0, slot: 4'd0, dropped: 1'b0,
                                 expired_count: 5'(e), net_count: n};
                     st_ff <= S_OUT;
                  end
               end
               idx_ff <= idx_ff + IW'(1);
            end
            S_OUT: if (!rsp_stall) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
